### rtl/core/pdmv_pkg.sv
package pdmv_pkg;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_VECTOR = 2'd1;
   localparam logic [1:0] ST_PARTIAL   = 2'd2;
   localparam logic [1:0] ST_SATURATED = 2'd3;

   localparam logic [9:0] DEFAULT_LENGTH = 10'd429;

   localparam int SUM_W    = 40;
   localparam int SQ_W     = 56;
   localparam int DIV_W    = 56;
   localparam int MEAN_W   = 24;
   localparam int VAR_W    = 32;
   localparam int OCOUNT_W = 24;

   localparam logic [MEAN_W-1:0] MEAN_POS_MAX = 24'h7FFFFF;
   localparam logic [MEAN_W:0]   MEAN_NEG_MAX = 25'h0800000;

   typedef struct packed {
      logic capture;
      logic clear;
      logic add_rd;
      logic add_wr;
      logic q_rd;
      logic div_start;
      logic div_sel_sq;
      logic mean_load;
      logic sq_mult;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic q_active;
      logic div_busy;
      logic rsp_free;
   } sts_type;

endpackage

### rtl/core/pdmv_ram.sv
module pdmv_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/pdmv_ctrl.sv
module pdmv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [1:0]        req_tuser,
   output logic              req_tready,
   input  pdmv_pkg::sts_type sts,
   output pdmv_pkg::cmd_type cmd
);
   import pdmv_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_RD,
      S_ADD_WR,
      S_Q_RD,
      S_Q_CHECK,
      S_MEAN_START,
      S_DIV_MEAN,
      S_SQ_START,
      S_DIV_SQ,
      S_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (op_type'(req_tuser))
                  OP_ADD:   state_in = S_ADD_RD;
                  OP_QUERY: state_in = S_Q_RD;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_NONE:  state_in = S_IDLE;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_RD: begin
            cmd.add_rd = 1'b1;
            state_in   = S_ADD_WR;
         end
         S_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = S_IDLE;
         end
         S_Q_RD: begin
            cmd.q_rd = 1'b1;
            state_in = S_Q_CHECK;
         end
         S_Q_CHECK: begin
            state_in = sts.q_active ? S_MEAN_START : S_LOAD;
         end
         S_MEAN_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_MEAN;
         end
         S_DIV_MEAN: begin
            if (!sts.div_busy) begin
               cmd.mean_load = 1'b1;
               state_in      = S_SQ_START;
            end
         end
         S_SQ_START: begin
            cmd.div_start  = 1'b1;
            cmd.div_sel_sq = 1'b1;
            cmd.sq_mult    = 1'b1;
            state_in       = S_DIV_SQ;
         end
         S_DIV_SQ: begin
            if (!sts.div_busy) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/pdmv_datapath.sv
module pdmv_datapath #(
   parameter int MAX_DIMENSIONS = 512,
   parameter int COUNT_BITS     = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       req_tdata,
   input  logic              csr_we,
   input  logic [9:0]        csr_wdata,
   input  pdmv_pkg::cmd_type cmd,
   output pdmv_pkg::sts_type sts,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [79:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser
);
   import pdmv_pkg::*;

   localparam int AW    = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
   localparam int DEPTH = 1 << AW;
   localparam int LEN_W = $clog2(MAX_DIMENSIONS + 1) > 0 ? $clog2(MAX_DIMENSIONS + 1) : 1;
   localparam int DEN_W = COUNT_BITS + 1;
   localparam int STEP_W = $clog2(DIV_W);

   logic [9:0]            vl_ff;
   logic signed [15:0]    sample_ff;
   logic [8:0]            qdim_ff;
   logic [31:0]           sqr_ff;
   logic [AW-1:0]         pos_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic                  sat_ff;

   logic [LEN_W-1:0]      eff_len;
   logic [AW-1:0]         rd_addr;
   logic [SUM_W-1:0]      sum_rd, sum_wr;
   logic [SQ_W-1:0]       sq_rd, sq_wr;
   logic                  wr_en;
   logic [LEN_W-1:0]      pos_next;
   logic [COUNT_BITS-1:0] cnt_next;
   logic [1:0]            status;

   logic [DIV_W-1:0]      quo_ff;
   logic [DEN_W-1:0]      rem_ff, den_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  busy_ff;
   logic [DEN_W:0]        trial;
   logic [SUM_W-1:0]      mag;
   logic [DIV_W-1:0]      dividend;

   logic [MEAN_W-1:0]     mean_ff;
   logic [MEAN_W-1:0]     mean_abs;
   logic [32:0]           msq_ff;
   logic [VAR_W-1:0]      ex2;
   logic [VAR_W-1:0]      var_val;

   logic                  rsp_valid_ff;
   logic [79:0]           rsp_data_ff;
   logic [1:0]            rsp_user_ff;

   always_comb begin
      if (vl_ff == 10'd0) begin
         eff_len = LEN_W'(1);
      end else if (int'(vl_ff) > MAX_DIMENSIONS) begin
         eff_len = LEN_W'(MAX_DIMENSIONS);
      end else begin
         eff_len = LEN_W'(vl_ff);
      end
   end

   assign rd_addr = cmd.q_rd ? AW'(qdim_ff) : pos_ff;
   assign wr_en   = cmd.add_wr && !sat_ff;

   always_comb begin
      if (cnt_ff == '0) begin
         sum_wr = SUM_W'(sample_ff);
         sq_wr  = SQ_W'(sqr_ff);
      end else begin
         sum_wr = sum_rd + SUM_W'(sample_ff);
         sq_wr  = sq_rd + SQ_W'(sqr_ff);
      end
   end

   pdmv_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_sum_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (pos_ff),
      .wdata (sum_wr),
      .re    (cmd.add_rd || cmd.q_rd),
      .raddr (rd_addr),
      .rdata (sum_rd)
   );

   pdmv_ram #(.WIDTH(SQ_W), .DEPTH(DEPTH)) u_sq_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (pos_ff),
      .wdata (sq_wr),
      .re    (cmd.add_rd || cmd.q_rd),
      .raddr (rd_addr),
      .rdata (sq_rd)
   );

   assign pos_next = LEN_W'(pos_ff) + LEN_W'(1);
   assign cnt_next = cnt_ff + COUNT_BITS'(1);

   always_comb begin
      if (sat_ff) begin
         status = ST_SATURATED;
      end else if (cnt_ff == '0) begin
         status = ST_NO_VECTOR;
      end else if (pos_ff != '0) begin
         status = ST_PARTIAL;
      end else begin
         status = ST_OK;
      end
   end

   assign sts.q_active = (status == ST_OK || status == ST_SATURATED) && (cnt_ff != '0)
                         && (int'(qdim_ff) < int'(eff_len));
   assign sts.div_busy = busy_ff;
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   assign mag      = sum_rd[SUM_W-1] ? (SUM_W'(0) - sum_rd) : sum_rd;
   assign dividend = cmd.div_sel_sq ? DIV_W'(sq_rd)
                                    : ({7'd0, mag, 9'd0} + DIV_W'(cnt_ff));
   assign trial    = {rem_ff, quo_ff[DIV_W-1]};

   assign mean_abs = mean_ff[MEAN_W-1] ? (MEAN_W'(0) - mean_ff) : mean_ff;
   assign ex2      = (quo_ff > DIV_W'(33'h0FFFFFFFF)) ? {VAR_W{1'b1}} : quo_ff[VAR_W-1:0];
   assign var_val  = (33'(ex2) > msq_ff) ? (ex2 - msq_ff[VAR_W-1:0]) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff        <= DEFAULT_LENGTH;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         sat_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            vl_ff <= csr_wdata;
         end
         if (cmd.clear) begin
            pos_ff <= '0;
            cnt_ff <= '0;
            sat_ff <= 1'b0;
         end else if (wr_en) begin
            if (pos_next >= eff_len) begin
               pos_ff <= '0;
               cnt_ff <= cnt_next;
               sat_ff <= (cnt_next == {COUNT_BITS{1'b1}});
            end else begin
               pos_ff <= AW'(pos_next);
            end
         end
         if (cmd.div_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(DIV_W - 1)) begin
            busy_ff <= 1'b0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_tdata[15:0];
         qdim_ff   <= req_tdata[24:16];
      end
      if (cmd.add_rd) begin
         sqr_ff <= 32'(sample_ff) * 32'(sample_ff);
      end
      if (cmd.div_start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         den_ff  <= cmd.div_sel_sq ? DEN_W'(cnt_ff) : {cnt_ff, 1'b0};
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + STEP_W'(1);
         if (trial >= (DEN_W + 1)'(den_ff)) begin
            rem_ff <= DEN_W'(trial - (DEN_W + 1)'(den_ff));
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= DEN_W'(trial);
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
      if (cmd.mean_load) begin
         if (sum_rd[SUM_W-1]) begin
            if (quo_ff > DIV_W'(MEAN_NEG_MAX)) begin
               mean_ff <= MEAN_W'(MEAN_NEG_MAX);
            end else begin
               mean_ff <= MEAN_W'(0) - quo_ff[MEAN_W-1:0];
            end
         end else begin
            if (quo_ff > DIV_W'(MEAN_POS_MAX)) begin
               mean_ff <= MEAN_POS_MAX;
            end else begin
               mean_ff <= quo_ff[MEAN_W-1:0];
            end
         end
      end
      if (cmd.sq_mult) begin
         msq_ff <= 33'((48'(mean_abs) * 48'(mean_abs) + 48'd32768) >> 16);
      end
      if (cmd.rsp_load) begin
         rsp_user_ff <= status;
         rsp_data_ff[79:56] <= (32'(cnt_ff) > 32'h00FFFFFF) ? {OCOUNT_W{1'b1}}
                                                          : OCOUNT_W'(cnt_ff);
         if (sts.q_active) begin
            rsp_data_ff[23:0]  <= mean_ff;
            rsp_data_ff[55:24] <= var_val;
         end else begin
            rsp_data_ff[55:0] <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/core/per_dimension_mean_variance.sv
// Per-dimension mean and variance accumulator. Add requests (tuser 0) feed
// Q8.8 elements into successive dimensions, each by a read-modify-write of
// the sum and square-sum RAMs. A query (tuser 1) returns mean (Q8.16),
// variance (Q16.16), vector count and status; when statistics exist it runs
// the shared 1-bit-per-cycle divider twice over 56 bits. A clear (tuser 2)
// resets the position, vector count and saturation flag. The result register
// lets new requests enter while a response waits.
module per_dimension_mean_variance #(
   parameter int MAX_DIMENSIONS = 512,
   parameter int COUNT_BITS     = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_value[15:0], query_dimension[24:16]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // mean_value[23:0], variance_value[55:24],
                                    // vector_count[79:56]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata
);
   import pdmv_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pdmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pdmv_datapath #(
      .MAX_DIMENSIONS (MAX_DIMENSIONS),
      .COUNT_BITS     (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/core/pdmv_checker.sv
module pdmv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import pdmv_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_NO_VECTOR) |->
         (rsp_tdata[55:0] == 56'd0) && (rsp_tdata[79:56] == 24'd0))
      else $error("statistics reported without vectors");

   a_partial_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_PARTIAL) |->
         (rsp_tdata[55:0] == 56'd0) && (rsp_tdata[79:56] != 24'd0))
      else $error("partial vector response malformed");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_OK) |-> (rsp_tdata[79:56] != 24'd0))
      else $error("ok status with zero count");

endmodule

bind per_dimension_mean_variance pdmv_checker u_pdmv_checker (.*);
